>>> src/ascii_integer_expression_evaluator_macros.svh
// Assertion macros shared by the checker of the expression evaluator.
`ifndef ASCII_INTEGER_EXPRESSION_EVALUATOR_MACROS_SVH
`define ASCII_INTEGER_EXPRESSION_EVALUATOR_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define AIE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define AIE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/aie_pkg.sv
package aie_pkg;

    // Pending operation codes.
    typedef enum logic [2:0] {
        OP_LOAD = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_MOD  = 3'd5
    } op_t;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_DIGIT = 2'd1;
    localparam logic [1:0] ST_ILLEGAL  = 2'd2;
    localparam logic [1:0] ST_ZERO_DIV = 2'd3;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RUN    = 4'b0010,
        S_FIX    = 4'b0100,
        S_FINISH = 4'b1000
    } state_t;

    // Characters the parser knows.
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_MINUS   = 8'h2D;
    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_PERCENT = 8'h25;

endpackage

>>> src/ascii_integer_expression_evaluator.sv
// Channel   Handshake                  Payload
// input     char_valid / char_stall    character[7:0], end_marker
// result    result_valid / result_stall value[31:0] (signed), status[1:0]
//
// A digit, a blank, a rejected character, or an operator whose pending operation is a
// load, an add, a subtract or a divide or modulo by zero is handled in the idle state.
// Otherwise a pending multiply, divide or modulo runs through the shared add/subtract
// unit one bit per cycle. An end word passes through the finish state to hand over the
// result. Reset is asynchronous, active low, and leaves an empty expression. The input
// is stalled while the sequencer is busy and while a finished result waits for the output.
module ascii_integer_expression_evaluator #(
    parameter int WORD_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               char_valid,
    output logic               char_stall,
    input  logic [7:0]         character,
    input  logic               end_marker,
    output logic               result_valid,
    input  logic               result_stall,
    output logic signed [31:0] value,
    output logic [1:0]         status
);

    localparam int CNT_W = $clog2(WORD_WIDTH);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_WIDTH - 1);

    aie_pkg::state_t state_reg, state_next;

    logic [WORD_WIDTH-1:0] acc_reg, acc_next;
    logic [WORD_WIDTH-1:0] opnd_reg, opnd_next;
    aie_pkg::op_t          pend_reg, pend_next;
    logic                  expect_reg, expect_next;
    logic [1:0]            perr_reg, perr_next;
    logic                  zdiv_reg, zdiv_next;

    aie_pkg::op_t          run_op_reg, run_op_next;
    logic                  end_flag_reg, end_flag_next;
    logic                  neg_reg, neg_next;
    logic [WORD_WIDTH-1:0] b_reg, b_next;
    logic [WORD_WIDTH-1:0] q_reg, q_next;
    logic [WORD_WIDTH-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]      count_reg, count_next;

    logic                  result_valid_reg, result_valid_next;
    logic signed [31:0]    value_reg, value_next;
    logic [1:0]            status_reg, status_next;

    // Shared add/subtract unit with a carry out.
    logic [WORD_WIDTH:0]   alu_x, alu_y;
    logic                  alu_sub;
    logic [WORD_WIDTH+1:0] alu_sum;

    logic                  is_digit, is_blank, is_op;
    aie_pkg::op_t          char_op;
    logic                  start_apply;
    logic [1:0]            perr_eff;
    logic                  acc_neg, opnd_neg;
    logic [WORD_WIDTH-1:0] acc_mag, opnd_mag, fix_word;
    logic [1:0]            final_status;

    assign char_stall   = (state_reg != aie_pkg::S_IDLE);
    assign result_valid = result_valid_reg;
    assign value        = value_reg;
    assign status       = status_reg;

    always_comb
    begin
        is_digit = (character >= aie_pkg::CH_ZERO) && (character <= aie_pkg::CH_NINE);
        is_blank = (character == aie_pkg::CH_SPACE) || (character == aie_pkg::CH_NEWLINE);
        is_op    = 1'b1;
        unique case (character)
            aie_pkg::CH_PLUS:    char_op = aie_pkg::OP_ADD;
            aie_pkg::CH_MINUS:   char_op = aie_pkg::OP_SUB;
            aie_pkg::CH_STAR:    char_op = aie_pkg::OP_MUL;
            aie_pkg::CH_SLASH:   char_op = aie_pkg::OP_DIV;
            aie_pkg::CH_PERCENT: char_op = aie_pkg::OP_MOD;
            default:
            begin
                char_op = aie_pkg::OP_LOAD;
                is_op   = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        acc_neg  = acc_reg[WORD_WIDTH-1];
        opnd_neg = opnd_reg[WORD_WIDTH-1];
        acc_mag  = acc_neg ? (~acc_reg + WORD_WIDTH'(1)) : acc_reg;
        opnd_mag = opnd_neg ? (~opnd_reg + WORD_WIDTH'(1)) : opnd_reg;
        fix_word = (run_op_reg == aie_pkg::OP_DIV) ? q_reg : rem_reg;
        perr_eff = (perr_reg == aie_pkg::ST_OK && expect_reg) ? aie_pkg::ST_NO_DIGIT
                                                             : perr_reg;
        final_status = (perr_reg != aie_pkg::ST_OK) ? perr_reg
                     : (zdiv_reg ? aie_pkg::ST_ZERO_DIV : aie_pkg::ST_OK);
    end

    // Multiply: product doubled plus the multiplicand when the multiplier bit is set.
    // Divide: restoring step, partial remainder with the next dividend bit minus divisor.
    always_comb
    begin
        alu_sub = (run_op_reg != aie_pkg::OP_MUL);
        if (alu_sub)
        begin
            alu_x = {rem_reg, q_reg[WORD_WIDTH-1]};
            alu_y = {1'b0, b_reg};
        end
        else
        begin
            alu_x = {1'b0, rem_reg[WORD_WIDTH-2:0], 1'b0};
            alu_y = {1'b0, q_reg[WORD_WIDTH-1] ? b_reg : '0};
        end
        alu_sum = {1'b0, alu_x} + {1'b0, alu_sub ? ~alu_y : alu_y}
                + (WORD_WIDTH+2)'(alu_sub);
    end

    always_comb
    begin
        state_next        = state_reg;
        acc_next          = acc_reg;
        opnd_next         = opnd_reg;
        pend_next         = pend_reg;
        expect_next       = expect_reg;
        perr_next         = perr_reg;
        zdiv_next         = zdiv_reg;
        run_op_next       = run_op_reg;
        end_flag_next     = end_flag_reg;
        neg_next          = neg_reg;
        b_next            = b_reg;
        q_next            = q_reg;
        rem_next          = rem_reg;
        count_next        = count_reg;
        result_valid_next = result_valid_reg && result_stall;
        value_next        = value_reg;
        status_next       = status_reg;
        start_apply       = 1'b0;

        unique case (state_reg)
            aie_pkg::S_IDLE:
            begin
                if (char_valid)
                begin
                    priority if (end_marker)
                    begin
                        perr_next     = perr_eff;
                        end_flag_next = 1'b1;
                        if (perr_eff == aie_pkg::ST_OK)
                        begin
                            start_apply = 1'b1;
                        end
                        else
                        begin
                            state_next = aie_pkg::S_FINISH;
                        end
                    end
                    else if (perr_reg != aie_pkg::ST_OK)
                    begin
                        // A latched error swallows everything up to the end word.
                    end
                    else if (is_digit)
                    begin
                        opnd_next = {opnd_reg[WORD_WIDTH-4:0], 3'b000}
                                  + {opnd_reg[WORD_WIDTH-2:0], 1'b0}
                                  + WORD_WIDTH'(character - aie_pkg::CH_ZERO);
                        expect_next = 1'b0;
                    end
                    else if (is_blank)
                    begin
                    end
                    else if (expect_reg)
                    begin
                        perr_next = aie_pkg::ST_NO_DIGIT;
                    end
                    else if (is_op)
                    begin
                        start_apply   = 1'b1;
                        pend_next     = char_op;
                        opnd_next     = '0;
                        expect_next   = 1'b1;
                        end_flag_next = 1'b0;
                    end
                    else
                    begin
                        perr_next = aie_pkg::ST_ILLEGAL;
                    end
                end

                if (start_apply)
                begin
                    state_next = end_marker ? aie_pkg::S_FINISH : aie_pkg::S_IDLE;
                    unique case (pend_reg)
                        aie_pkg::OP_ADD: acc_next = acc_reg + opnd_reg;
                        aie_pkg::OP_SUB: acc_next = acc_reg - opnd_reg;
                        aie_pkg::OP_MUL, aie_pkg::OP_DIV, aie_pkg::OP_MOD:
                        begin
                            if (pend_reg != aie_pkg::OP_MUL && opnd_reg == '0)
                            begin
                                zdiv_next = 1'b1;
                            end
                            else
                            begin
                                run_op_next = pend_reg;
                                b_next      = (pend_reg == aie_pkg::OP_MUL) ? opnd_reg
                                                                           : opnd_mag;
                                q_next      = (pend_reg == aie_pkg::OP_MUL) ? acc_reg
                                                                           : acc_mag;
                                rem_next    = '0;
                                count_next  = '0;
                                neg_next    = (pend_reg == aie_pkg::OP_DIV) ? (acc_neg ^ opnd_neg)
                                            : (pend_reg == aie_pkg::OP_MOD) ? acc_neg : 1'b0;
                                state_next  = aie_pkg::S_RUN;
                            end
                        end
                        default: acc_next = opnd_reg;
                    endcase
                end
            end

            aie_pkg::S_RUN:
            begin
                if (alu_sub)
                begin
                    if (alu_sum[WORD_WIDTH+1])
                    begin
                        rem_next = alu_sum[WORD_WIDTH-1:0];
                        q_next   = {q_reg[WORD_WIDTH-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_next = alu_x[WORD_WIDTH-1:0];
                        q_next   = {q_reg[WORD_WIDTH-2:0], 1'b0};
                    end
                end
                else
                begin
                    rem_next = alu_sum[WORD_WIDTH-1:0];
                    q_next   = {q_reg[WORD_WIDTH-2:0], 1'b0};
                end
                if (count_reg == CNT_LAST)
                begin
                    state_next = aie_pkg::S_FIX;
                end
                else
                begin
                    count_next = count_reg + CNT_W'(1);
                end
            end

            aie_pkg::S_FIX:
            begin
                acc_next   = neg_reg ? (~fix_word + WORD_WIDTH'(1)) : fix_word;
                state_next = end_flag_reg ? aie_pkg::S_FINISH : aie_pkg::S_IDLE;
            end

            aie_pkg::S_FINISH:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    status_next       = final_status;
                    value_next        = (final_status == aie_pkg::ST_OK)
                                      ? 32'($signed(acc_reg)) : '0;
                    acc_next          = '0;
                    opnd_next         = '0;
                    pend_next         = aie_pkg::OP_LOAD;
                    expect_next       = 1'b0;
                    perr_next         = aie_pkg::ST_OK;
                    zdiv_next         = 1'b0;
                    state_next        = aie_pkg::S_IDLE;
                end
            end

            default: state_next = aie_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= aie_pkg::S_IDLE;
            acc_reg          <= '0;
            opnd_reg         <= '0;
            pend_reg         <= aie_pkg::OP_LOAD;
            expect_reg       <= 1'b0;
            perr_reg         <= aie_pkg::ST_OK;
            zdiv_reg         <= 1'b0;
            end_flag_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            acc_reg          <= acc_next;
            opnd_reg         <= opnd_next;
            pend_reg         <= pend_next;
            expect_reg       <= expect_next;
            perr_reg         <= perr_next;
            zdiv_reg         <= zdiv_next;
            end_flag_reg     <= end_flag_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        run_op_reg <= run_op_next;
        neg_reg    <= neg_next;
        b_reg      <= b_next;
        q_reg      <= q_next;
        rem_reg    <= rem_next;
        count_reg  <= count_next;
        value_reg  <= value_next;
        status_reg <= status_next;
    end

endmodule

>>> src/aie_checker.sv
`include "ascii_integer_expression_evaluator_macros.svh"

module aie_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               char_valid,
    input logic               char_stall,
    input logic [7:0]         character,
    input logic               end_marker,
    input logic               result_valid,
    input logic               result_stall,
    input logic signed [31:0] value,
    input logic [1:0]         status
);

    // Any failing status carries a zero value.
    `AIE_ASSERT_SAME(a_error_value_zero, result_valid && status != aie_pkg::ST_OK, value == '0, "error result with nonzero value")

    // An accepted end word always stalls the input in the following cycle.
    `AIE_ASSERT_NEXT(a_end_busy, char_valid && !char_stall && end_marker, char_stall, "input not stalled after end word")

    // A digit leaves the input unstalled in the next cycle.
    `AIE_ASSERT_NEXT(a_digit_fast, char_valid && !char_stall && !end_marker && character >= aie_pkg::CH_ZERO && character <= aie_pkg::CH_NINE, !char_stall, "digit word stalled the input")

    // A stalled result word holds.
    `AIE_ASSERT_NEXT(a_result_hold, result_valid && result_stall, result_valid && $stable(value) && $stable(status), "stalled result word changed")

endmodule

bind ascii_integer_expression_evaluator aie_checker u_aie_checker (.*);
